[sv/uart_rb_pkg.sv]
// Shared types, register offsets, command codes and queue pointer helpers
// for the serial port register block. No dependencies.
`default_nettype none

package uart_rb_pkg;

  // Depth of each byte queue; pointers run modulo twice the depth.
  localparam int unsigned QUEUE_DEPTH = 64;
  localparam int unsigned PTR_W       = $clog2(2 * QUEUE_DEPTH);
  localparam int unsigned IDX_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  typedef logic [PTR_W-1:0] ptr_t;
  typedef logic [IDX_W-1:0] idx_t;

  localparam ptr_t PTR_DEPTH = ptr_t'(QUEUE_DEPTH);
  localparam ptr_t PTR_LAST  = ptr_t'(2 * QUEUE_DEPTH - 1);

  // Input command codes.
  localparam logic [1:0] CMD_READ  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_RX    = 2'd2;
  localparam logic [1:0] CMD_TICK  = 2'd3;

  // Register offsets.
  localparam logic [2:0] REG_DATA = 3'd0;
  localparam logic [2:0] REG_IER  = 3'd1;
  localparam logic [2:0] REG_IIR  = 3'd2;
  localparam logic [2:0] REG_LCR  = 3'd3;
  localparam logic [2:0] REG_MCR  = 3'd4;
  localparam logic [2:0] REG_LSR  = 3'd5;
  localparam logic [2:0] REG_MSR  = 3'd6;
  localparam logic [2:0] REG_SCR  = 3'd7;

  // Interrupt identification values.
  localparam logic [7:0] IIR_RX_DATA = 8'h04;
  localparam logic [7:0] IIR_TX_EMPTY = 8'h02;
  localparam logic [7:0] IIR_NONE    = 8'h01;

  localparam int unsigned LCR_DLAB_BIT = 7;
  localparam int unsigned IER_RX_BIT   = 0;
  localparam int unsigned IER_TX_BIT   = 1;

  typedef enum logic [1:0] {
    KIND_READ  = 2'd0,
    KIND_WRITE = 2'd1,
    KIND_RX    = 2'd2,
    KIND_TICK  = 2'd3
  } kind_e;

  typedef struct packed {
    logic [1:0] command;
    logic [2:0] reg_offset;
    logic [7:0] write_data;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       irq;
    logic       tx_valid;
    logic [7:0] tx_byte;
  } out_item_t;

  // Classified operation handed from the front part to the back part.
  typedef struct packed {
    kind_e      kind;
    logic [2:0] offset;
    logic [7:0] data;
  } op_t;

  function automatic ptr_t ptr_next(input ptr_t p);
    ptr_t n;
    n = (p == PTR_LAST) ? '0 : ptr_t'(p + ptr_t'(1));
    return n;
  endfunction

  function automatic idx_t ptr_idx(input ptr_t p);
    ptr_t r;
    r = (p >= PTR_DEPTH) ? ptr_t'(p - PTR_DEPTH) : p;
    return idx_t'(r);
  endfunction

  function automatic logic q_full(input ptr_t head, input ptr_t tail);
    logic [PTR_W:0] diff;
    diff = {1'b0, tail} - {1'b0, head};
    if (tail < head) begin
      diff = diff + (PTR_W + 1)'(2 * QUEUE_DEPTH);
    end
    return (diff >= (PTR_W + 1)'(QUEUE_DEPTH));
  endfunction

endpackage

`default_nettype wire

[sv/uart_rb_front.sv]
// Front part: accepts words, classifies them and holds them in a short queue.
// Depends on uart_rb_pkg.
`default_nettype none

module uart_rb_front (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start_i,
  input  wire uart_rb_pkg::in_item_t in_item_i,
  output logic                      busy_o,
  output logic                      op_valid_o,
  output uart_rb_pkg::op_t          op_o,
  input  wire logic                 op_take_i
);
  import uart_rb_pkg::*;

  op_t        slot_q [2];
  logic       wr_q, wr_d, rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push, pop;
  op_t        op_new;

  always_comb begin
    op_new.offset = in_item_i.reg_offset;
    op_new.data   = in_item_i.write_data;
    unique case (in_item_i.command)
      CMD_READ:  op_new.kind = KIND_READ;
      CMD_WRITE: op_new.kind = KIND_WRITE;
      CMD_RX: begin
        op_new.kind = KIND_RX;
        op_new.data = in_item_i.rx_byte;
      end
      default:   op_new.kind = KIND_TICK;
    endcase
  end

  assign busy_o     = (cnt_q == 2'd2);
  assign push       = start_i && !busy_o;
  assign op_valid_o = (cnt_q != 2'd0);
  assign op_o       = slot_q[rd_q];
  assign pop        = op_valid_o && op_take_i;

  always_comb begin
    wr_d  = push ? ~wr_q : wr_q;
    rd_d  = pop ? ~rd_q : rd_q;
    cnt_d = 2'(cnt_q + {1'b0, push} - {1'b0, pop});
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_q] <= op_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

`default_nettype wire

[sv/uart_rb_back.sv]
// Back part: register file, receive and transmit byte queues, result stage.
// Depends on uart_rb_pkg.
`default_nettype none

module uart_rb_back (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              op_valid_i,
  input  wire uart_rb_pkg::op_t  op_i,
  output logic                   op_take_o,
  output logic                   done_o,
  output uart_rb_pkg::out_item_t out_item_o
);
  import uart_rb_pkg::*;

  logic [7:0] rx_mem [QUEUE_DEPTH];
  logic [7:0] tx_mem [QUEUE_DEPTH];
  logic [7:0] rx_rd_q, tx_rd_q;

  ptr_t       rx_head_q, rx_head_d, rx_tail_q, rx_tail_d;
  ptr_t       tx_head_q, tx_head_d, tx_tail_q, tx_tail_d;
  logic [3:0] ier_q, ier_d;
  logic [7:0] lcr_q, lcr_d;
  logic [4:0] mcr_q, mcr_d;
  logic [7:0] scr_q, scr_d;
  logic [15:0] div_q, div_d;
  logic       ovr_q, ovr_d;

  logic       done_q, sel_rx_q, txv_q, irq_q;
  logic [7:0] rd_q;
  logic       sel_rx_d, txv_d, irq_d;
  logic [7:0] rd_d;

  logic rx_empty, tx_empty, rx_full, tx_full, dlab, rx_int, tx_int;
  logic rx_push, tx_push;

  assign op_take_o = 1'b1;
  assign rx_empty  = (rx_head_q == rx_tail_q);
  assign tx_empty  = (tx_head_q == tx_tail_q);
  assign rx_full   = q_full(rx_head_q, rx_tail_q);
  assign tx_full   = q_full(tx_head_q, tx_tail_q);
  assign dlab      = lcr_q[LCR_DLAB_BIT];
  assign rx_int    = ier_q[IER_RX_BIT] && !rx_empty;
  assign tx_int    = ier_q[IER_TX_BIT] && tx_empty;

  always_comb begin
    rx_head_d = rx_head_q;
    rx_tail_d = rx_tail_q;
    tx_head_d = tx_head_q;
    tx_tail_d = tx_tail_q;
    ier_d = ier_q;
    lcr_d = lcr_q;
    mcr_d = mcr_q;
    scr_d = scr_q;
    div_d = div_q;
    ovr_d = ovr_q;
    rd_d = 8'h00;
    sel_rx_d = 1'b0;
    txv_d = 1'b0;
    rx_push = 1'b0;
    tx_push = 1'b0;
    if (op_valid_i) begin
      unique case (op_i.kind)
        KIND_READ: begin
          unique case (op_i.offset)
            REG_DATA: begin
              if (dlab) begin
                rd_d = div_q[7:0];
              end else if (!rx_empty) begin
                sel_rx_d  = 1'b1;
                rx_head_d = ptr_next(rx_head_q);
              end
            end
            REG_IER:  rd_d = dlab ? div_q[15:8] : {4'h0, ier_q};
            REG_IIR:  rd_d = rx_int ? IIR_RX_DATA : (tx_int ? IIR_TX_EMPTY : IIR_NONE);
            REG_LCR:  rd_d = lcr_q;
            REG_MCR:  rd_d = {3'b000, mcr_q};
            REG_LSR: begin
              rd_d  = {1'b0, tx_empty, tx_empty, 3'b000, ovr_q, !rx_empty};
              ovr_d = 1'b0;
            end
            REG_MSR:  rd_d = 8'h00;
            default:  rd_d = scr_q;
          endcase
        end
        KIND_WRITE: begin
          unique case (op_i.offset)
            REG_DATA: begin
              if (dlab) begin
                div_d[7:0] = op_i.data;
              end else if (!tx_full) begin
                tx_push   = 1'b1;
                tx_tail_d = ptr_next(tx_tail_q);
              end
            end
            REG_IER: begin
              if (dlab) begin
                div_d[15:8] = op_i.data;
              end else begin
                ier_d = op_i.data[3:0];
              end
            end
            REG_LCR: lcr_d = op_i.data;
            REG_MCR: mcr_d = op_i.data[4:0];
            REG_SCR: scr_d = op_i.data;
            default: ;
          endcase
        end
        KIND_RX: begin
          if (rx_full) begin
            ovr_d = 1'b1;
          end else begin
            rx_push   = 1'b1;
            rx_tail_d = ptr_next(rx_tail_q);
          end
        end
        default: begin
          if (!tx_empty) begin
            txv_d     = 1'b1;
            tx_head_d = ptr_next(tx_head_q);
          end
        end
      endcase
    end
    irq_d = (ier_d[IER_RX_BIT] && (rx_head_d != rx_tail_d)) ||
            (ier_d[IER_TX_BIT] && (tx_head_d == tx_tail_d));
  end

  // Both stores are written at the tail on a push and read at the head each
  // cycle; the registered head entry is used only when the item popped it.
  always_ff @(posedge clk_i) begin
    if (rx_push) begin
      rx_mem[ptr_idx(rx_tail_q)] <= op_i.data;
    end
    rx_rd_q <= rx_mem[ptr_idx(rx_head_q)];
  end

  always_ff @(posedge clk_i) begin
    if (tx_push) begin
      tx_mem[ptr_idx(tx_tail_q)] <= op_i.data;
    end
    tx_rd_q <= tx_mem[ptr_idx(tx_head_q)];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_head_q <= '0;
      rx_tail_q <= '0;
      tx_head_q <= '0;
      tx_tail_q <= '0;
      ier_q     <= '0;
      lcr_q     <= '0;
      mcr_q     <= '0;
      scr_q     <= '0;
      div_q     <= '0;
      ovr_q     <= 1'b0;
      done_q    <= 1'b0;
      sel_rx_q  <= 1'b0;
      txv_q     <= 1'b0;
      irq_q     <= 1'b0;
      rd_q      <= '0;
    end else begin
      rx_head_q <= rx_head_d;
      rx_tail_q <= rx_tail_d;
      tx_head_q <= tx_head_d;
      tx_tail_q <= tx_tail_d;
      ier_q     <= ier_d;
      lcr_q     <= lcr_d;
      mcr_q     <= mcr_d;
      scr_q     <= scr_d;
      div_q     <= div_d;
      ovr_q     <= ovr_d;
      done_q    <= op_valid_i;
      sel_rx_q  <= sel_rx_d;
      txv_q     <= txv_d;
      irq_q     <= irq_d;
      rd_q      <= rd_d;
    end
  end

  assign done_o               = done_q;
  assign out_item_o.read_data = !done_q ? 8'h00 : (sel_rx_q ? rx_rd_q : rd_q);
  assign out_item_o.irq       = done_q && irq_q;
  assign out_item_o.tx_valid  = done_q && txv_q;
  assign out_item_o.tx_byte   = (done_q && txv_q) ? tx_rd_q : 8'h00;

endmodule

`default_nettype wire

[sv/uart_register_block_with_queues_core.sv]
// Path: a word accepted at a clock edge is stored in the operation queue,
// then carried out by the back part and registered in its result stage.
// Throughput: one word per cycle; the back part retires an operation in every
// cycle, so busy_o only rises if the operation queue were ever to fill.
// Reset: rst_ni clears the registers and queue pointers at once, except the
// queue slots, byte stores and their read ports, used only once written.
// Top level of the serial port register block; uses uart_rb_pkg,
// uart_rb_front and uart_rb_back.
`default_nettype none

module uart_register_block_with_queues_core (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start_i,
  input  wire uart_rb_pkg::in_item_t in_item_i,
  output logic                       busy_o,
  output logic                       done_o,
  output uart_rb_pkg::out_item_t     out_item_o
);
  import uart_rb_pkg::*;

  // The front part decodes each word into an operation: bus read, bus write,
  // received line byte or transmitter tick, with the relevant byte already
  // picked. A two-entry queue separates it from the back part.
  logic op_valid;
  logic op_take;
  op_t  op;

  uart_rb_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .in_item_i  (in_item_i),
    .busy_o     (busy_o),
    .op_valid_o (op_valid),
    .op_o       (op),
    .op_take_i  (op_take)
  );

  // The back part holds the registers and both byte queues. It carries out
  // one operation per cycle, and the result stage presents the word for
  // exactly one cycle with done_o high; popped bytes come straight from the
  // registered read port of the relevant store.
  uart_rb_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .op_valid_i (op_valid),
    .op_i       (op),
    .op_take_o  (op_take),
    .done_o     (done_o),
    .out_item_o (out_item_o)
  );

endmodule

`default_nettype wire

[sv/uart_rb_chk.sv]
// Port-level checker for the serial port register block, bound to the top
// level. Depends on uart_rb_pkg.
`default_nettype none

module uart_rb_chk (
  input wire logic                  clk_i,
  input wire logic                  rst_ni,
  input wire logic                  start_i,
  input wire uart_rb_pkg::in_item_t in_item_i,
  input wire logic                  busy_o,
  input wire logic                  done_o,
  input wire uart_rb_pkg::out_item_t out_item_o
);
  import uart_rb_pkg::*;

  // Every accepted word gives its result once through the queue and result stage.
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##2 done_o)
    else $error("accepted word produced no result");

  // No result without a correspondingly earlier accepted word.
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i && !busy_o, 2))
    else $error("result without an accepted word");

  // A byte leaves on the line only for a transmitter tick.
  a_tx_only_on_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && out_item_o.tx_valid) |-> $past(in_item_i.command == CMD_TICK, 2))
    else $error("transmit byte without a tick");

  // Read data is non-zero only for a bus read.
  a_read_data_only_on_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (out_item_o.read_data != 8'h00)) |->
      $past(in_item_i.command == CMD_READ, 2))
    else $error("read data on a non-read word");

endmodule

bind uart_register_block_with_queues_core uart_rb_chk u_uart_rb_chk (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .start_i    (start_i),
  .in_item_i  (in_item_i),
  .busy_o     (busy_o),
  .done_o     (done_o),
  .out_item_o (out_item_o)
);

`default_nettype wire

[sim/uart_register_block_with_queues_core_tb.sv]
// Self-checking testbench for the serial port register block with byte queues.
// Depends on uart_rb_pkg and uart_register_block_with_queues_core only.
module uart_register_block_with_queues_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import uart_rb_pkg::*;

  // Clock and reset. The reset is held low from time zero and released once.
  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  // Command side of the block. Every input has a known value from the start.
  logic start_i = 1'b0;
  in_item_t in_item_i = '0;
  logic busy_o;
  logic done_o;
  out_item_t out_item_o;

  uart_register_block_with_queues_core u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .in_item_i  (in_item_i),
    .busy_o     (busy_o),
    .done_o     (done_o),
    .out_item_o (out_item_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Shadow copy of the register file and both byte queues. The queues are held
  // as plain SystemVerilog queues, bounded at QUEUE_DEPTH, so the pointer
  // arithmetic of the block is checked against a simple count. The registers
  // start at their reset values, since the block is reset once at time zero.
  logic [7:0]  rx_bytes[$];
  logic [7:0]  tx_bytes[$];
  logic [3:0]  ier_shadow = '0;
  logic [7:0]  lcr_shadow = '0;
  logic [4:0]  mcr_shadow = '0;
  logic [7:0]  scr_shadow = '0;
  logic [15:0] divisor_shadow = '0;
  logic        overrun_shadow = 1'b0;

  // Expected responses, oldest first, and the bookkeeping for the summary.
  out_item_t   pending_responses[$];
  out_item_t   next_response;
  int unsigned error_count = 0;
  int unsigned words_sent = 0;
  int unsigned responses_checked = 0;
  int unsigned rx_queued = 0;
  int unsigned rx_overruns = 0;
  int unsigned tx_sent = 0;
  int unsigned tx_dropped = 0;
  int unsigned idle_pct = 0;

  function automatic logic rx_irq_pending();
    return ier_shadow[IER_RX_BIT] && (rx_bytes.size() != 0);
  endfunction

  function automatic logic tx_irq_pending();
    return ier_shadow[IER_TX_BIT] && (tx_bytes.size() == 0);
  endfunction

  // Works out the response to one accepted word and moves the shadow state on.
  // The interrupt level is taken after the word has had its effect.
  function automatic out_item_t predict_uart_response(input in_item_t w);
    out_item_t r;
    logic      dlab;
    logic      tx_empty;
    r = '0;
    dlab = lcr_shadow[LCR_DLAB_BIT];
    case (w.command)
      CMD_READ: begin
        case (w.reg_offset)
          REG_DATA: begin
            if (dlab) begin
              r.read_data = divisor_shadow[7:0];
            end else if (rx_bytes.size() != 0) begin
              r.read_data = rx_bytes.pop_front();
            end
          end
          REG_IER: r.read_data = dlab ? divisor_shadow[15:8] : {4'b0000, ier_shadow};
          REG_IIR: begin
            // Receive data outranks an empty transmit queue.
            if (rx_irq_pending()) begin
              r.read_data = IIR_RX_DATA;
            end else if (tx_irq_pending()) begin
              r.read_data = IIR_TX_EMPTY;
            end else begin
              r.read_data = IIR_NONE;
            end
          end
          REG_LCR: r.read_data = lcr_shadow;
          REG_MCR: r.read_data = {3'b000, mcr_shadow};
          REG_LSR: begin
            // Reading line status is the only thing that clears overrun.
            tx_empty = (tx_bytes.size() == 0);
            r.read_data = {1'b0, tx_empty, tx_empty, 3'b000, overrun_shadow,
                           rx_bytes.size() != 0};
            overrun_shadow = 1'b0;
          end
          REG_MSR: r.read_data = 8'h00;
          default: r.read_data = scr_shadow;
        endcase
      end
      CMD_WRITE: begin
        case (w.reg_offset)
          REG_DATA: begin
            if (dlab) begin
              divisor_shadow[7:0] = w.write_data;
            end else if (tx_bytes.size() < QUEUE_DEPTH) begin
              tx_bytes.push_back(w.write_data);
            end else begin
              tx_dropped++;
            end
          end
          REG_IER: begin
            if (dlab) begin
              divisor_shadow[15:8] = w.write_data;
            end else begin
              ier_shadow = w.write_data[3:0];
            end
          end
          REG_LCR: lcr_shadow = w.write_data;
          REG_MCR: mcr_shadow = w.write_data[4:0];
          REG_SCR: scr_shadow = w.write_data;
          default: ;
        endcase
      end
      CMD_RX: begin
        if (rx_bytes.size() >= QUEUE_DEPTH) begin
          overrun_shadow = 1'b1;
          rx_overruns++;
        end else begin
          rx_bytes.push_back(w.rx_byte);
          rx_queued++;
        end
      end
      default: begin
        if (tx_bytes.size() != 0) begin
          r.tx_valid = 1'b1;
          r.tx_byte = tx_bytes.pop_front();
          tx_sent++;
        end
      end
    endcase
    r.irq = rx_irq_pending() || tx_irq_pending();
    return r;
  endfunction

  task automatic compare_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      error_count++;
    end
  endtask

  // Watches both sides at every rising edge. A word accepted at this edge is
  // predicted before any result at the same edge is taken, so the order of
  // the two is fixed regardless of how the simulator schedules processes.
  always @(posedge clk_i) begin
    if (rst_ni && start_i && !busy_o) begin
      pending_responses.push_back(predict_uart_response(in_item_i));
    end
    if (rst_ni && done_o) begin
      if (pending_responses.size() == 0) begin
        $display("%0t: result with nothing expected, expected none, actual %h",
                 $time, out_item_o);
        error_count++;
      end else begin
        next_response = pending_responses.pop_front();
        compare_field("read_data", next_response.read_data, out_item_o.read_data);
        compare_field("irq", 8'(next_response.irq), 8'(out_item_o.irq));
        compare_field("tx_valid", 8'(next_response.tx_valid), 8'(out_item_o.tx_valid));
        compare_field("tx_byte", next_response.tx_byte, out_item_o.tx_byte);
        responses_checked++;
      end
    end
  end

  // Presents one word and returns at the edge that accepts it. Start is left
  // high so that back-to-back words need no second assignment in one step;
  // the next call or a drain lowers it when a gap is wanted.
  task automatic send_word(input logic [1:0] cmd, input logic [2:0] off,
                           input logic [7:0] wd, input logic [7:0] rb);
    in_item_t w;
    w.command = cmd;
    w.reg_offset = off;
    w.write_data = wd;
    w.rx_byte = rb;
    if ($urandom_range(0, 99) < idle_pct) begin
      start_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < idle_pct);
    end
    start_i <= 1'b1;
    in_item_i <= w;
    do @(posedge clk_i); while (busy_o);
    words_sent++;
  endtask

  // Unused fields carry random values so that their bits toggle as well.
  task automatic bus_read(input logic [2:0] off);
    send_word(CMD_READ, off, 8'($urandom), 8'($urandom));
  endtask

  task automatic bus_write(input logic [2:0] off, input logic [7:0] d);
    send_word(CMD_WRITE, off, d, 8'($urandom));
  endtask

  task automatic line_byte(input logic [7:0] b);
    send_word(CMD_RX, 3'($urandom), 8'($urandom), b);
  endtask

  task automatic tx_tick();
    send_word(CMD_TICK, 3'($urandom), 8'($urandom), 8'($urandom));
  endtask

  // Holds the sender off until every outstanding result has been checked,
  // polling on the falling edge and handing back control on a rising one.
  task automatic drain_responses();
    int unsigned guard;
    guard = 0;
    start_i <= 1'b0;
    do begin
      @(negedge clk_i);
      guard++;
    end while (pending_responses.size() != 0 && guard < 200);
    @(posedge clk_i);
  endtask

  task automatic test_reset_state();
    bus_read(REG_DATA);   // empty receive register reads zero
    bus_read(REG_IIR);
    bus_read(REG_LSR);
  endtask

  task automatic test_register_file();
    bus_write(REG_IER, 8'hFF);   // only the low four bits are kept
    bus_write(REG_MCR, 8'hFF);   // only the low five bits are kept
    bus_write(REG_SCR, 8'hFF);
    bus_write(REG_IIR, 8'hFF);   // FIFO control, ignored
    bus_write(REG_MSR, 8'hFF);   // ignored
    bus_read(REG_IER);
    bus_read(REG_MCR);
    bus_read(REG_SCR);
    bus_read(REG_MSR);
    bus_write(REG_SCR, 8'h00);
  endtask

  task automatic test_divisor_latch();
    bus_write(REG_LCR, 8'h80);
    bus_write(REG_DATA, 8'hFF);  // divisor low byte, not the transmit queue
    bus_write(REG_IER, 8'h00);   // divisor high byte
    bus_read(REG_DATA);
    bus_read(REG_IER);
    bus_write(REG_LCR, 8'h7F);
    bus_read(REG_LCR);
  endtask

  task automatic test_queue_basics();
    line_byte(8'hFF);
    line_byte(8'h00);
    bus_read(REG_IIR);           // receive data pending
    bus_read(REG_DATA);
    bus_read(REG_DATA);
    bus_read(REG_DATA);          // now empty
    bus_write(REG_DATA, 8'h5A);
    tx_tick();
    tx_tick();                   // nothing left to send
    bus_read(REG_LSR);
  endtask

  // Mostly well-formed sequences with random content: bursts that fill and
  // overfill a queue and then empty it, divisor and enable updates, and
  // write-then-read pairs, with a share of fully random words as noise.
  task automatic test_random_traffic(input int unsigned n_words, input int unsigned pct);
    int unsigned target;
    int unsigned kind;
    logic [2:0]  off;
    idle_pct = pct;
    target = words_sent + n_words;
    while (words_sent < target) begin
      kind = $urandom_range(0, 9);
      case (kind)
        0, 1: send_word(2'($urandom), 3'($urandom), 8'($urandom), 8'($urandom));
        2, 3: begin
          bus_write(REG_LCR, {1'b0, 7'($urandom)});
          repeat ($urandom_range(1, 70)) line_byte(8'($urandom));
          repeat ($urandom_range(1, 70)) begin
            bus_read(($urandom_range(0, 7) == 0) ? REG_LSR : REG_DATA);
          end
        end
        4, 5: begin
          bus_write(REG_LCR, {1'b0, 7'($urandom)});
          bus_write(REG_IER, 8'($urandom));
          repeat ($urandom_range(1, 70)) bus_write(REG_DATA, 8'($urandom));
          repeat ($urandom_range(1, 70)) begin
            if ($urandom_range(0, 7) == 0) begin
              bus_read(REG_IIR);
            end else begin
              tx_tick();
            end
          end
        end
        6: begin
          bus_write(REG_LCR, {1'b1, 7'($urandom)});
          bus_write(REG_DATA, 8'($urandom));
          bus_write(REG_IER, 8'($urandom));
          bus_read(REG_DATA);
          bus_read(REG_IER);
          bus_write(REG_LCR, {1'b0, 7'($urandom)});
        end
        7: begin
          bus_write(REG_IER, 8'($urandom));
          bus_read(REG_IIR);
          bus_read(REG_IER);
        end
        8: begin
          off = 3'($urandom);
          bus_write(off, 8'($urandom));
          bus_read(off);
        end
        default: begin
          repeat (8) begin
            case ($urandom_range(0, 3))
              0: line_byte(8'($urandom));
              1: tx_tick();
              2: bus_read(REG_LSR);
              default: bus_read(REG_MSR);
            endcase
          end
        end
      endcase
    end
    drain_responses();
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_reset_state();
    test_register_file();
    test_divisor_latch();
    test_queue_basics();
    drain_responses();

    // Sender idles now and then, then most of the time, then not at all.
    test_random_traffic(200, 32);
    test_random_traffic(200, 74);
    test_random_traffic(200, 0);

    repeat (8) @(posedge clk_i);
    if (pending_responses.size() != 0) begin
      $display("%0t: results missing, expected %0d more, actual 0", $time,
               pending_responses.size());
      error_count++;
    end

    $display("Sent %0d words and checked %0d results under three sender idle rates.",
             words_sent, responses_checked);
    $display("Line bytes queued %0d, overruns %0d, bytes sent %0d, transmit drops %0d.",
             rx_queued, rx_overruns, tx_sent, tx_dropped);
    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Far beyond the slowest correct run.
  initial begin
    #2_000_000;
    $display("Timed out waiting for the block.");
    $display("CHECK FAILED");
    $finish;
  end

endmodule

[filelist.f]
sv/uart_rb_pkg.sv
sv/uart_rb_front.sv
sv/uart_rb_back.sv
sv/uart_register_block_with_queues_core.sv
sv/uart_rb_chk.sv
sim/uart_register_block_with_queues_core_tb.sv
